@@ design/rpe_pkg.sv @@
`default_nettype none
package rpe_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumLane = 3;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned RegIdxW = 3;
  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  typedef enum logic [ModeW-1:0] {
    MODE_INVERT   = 3'd0,
    MODE_CLEAR    = 3'd1,
    MODE_CAP      = 3'd2,
    MODE_DIM      = 3'd3,
    MODE_CONTRAST = 3'd4,
    MODE_SWAP     = 3'd5,
    MODE_COMBINE  = 3'd6
  } effect_mode_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_EFFECT_MODE     = 3'd0,
    REG_CLEAR_MASK      = 3'd1,
    REG_CAP_LEVEL       = 3'd2,
    REG_DIM_AMOUNT      = 3'd3,
    REG_CONTRAST_FACTOR = 3'd4,
    REG_CONTRAST_LOW    = 3'd5,
    REG_CONTRAST_HIGH   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic [ChanW-1:0] second_red;
    logic [ChanW-1:0] second_green;
    logic [ChanW-1:0] second_blue;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
  } pix_out_t;

  // Settings shared by every lane.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ChanW-1:0] cap_level;
    logic [ChanW-1:0] dim_amount;
    logic [ChanW-1:0] contrast_factor;
    logic [ChanW-1:0] contrast_low;
    logic [ChanW-1:0] contrast_high;
  } lane_cfg_t;

endpackage
`default_nettype wire

@@ design/rpe_lane.sv @@
`default_nettype none
module rpe_lane
  import rpe_pkg::*;
(
  input  wire lane_cfg_t        cfg_i,
  input  wire logic             clear_i,
  input  wire logic [ChanW-1:0] chan_i,
  input  wire logic [ChanW-1:0] other_i,
  output logic      [ChanW-1:0] chan_o
);

  logic [ChanW:0]   sum_hi;
  logic [ChanW:0]   sum_avg;
  logic [ChanW-1:0] dim_res;
  logic [ChanW-1:0] con_res;

  assign sum_hi  = {1'b0, chan_i} + {1'b0, cfg_i.contrast_factor};
  assign sum_avg = {1'b0, chan_i} + {1'b0, other_i};
  assign dim_res = (chan_i <= cfg_i.dim_amount) ? '0 : chan_i - cfg_i.dim_amount;

  always_comb begin
    if (chan_i >= cfg_i.contrast_high) begin
      con_res = sum_hi[ChanW] ? ChanMax : sum_hi[ChanW-1:0];
    end else if (chan_i <= cfg_i.contrast_low) begin
      con_res = (chan_i <= cfg_i.contrast_factor) ? '0 : chan_i - cfg_i.contrast_factor;
    end else begin
      con_res = chan_i;
    end
  end

  always_comb begin
    case (cfg_i.mode)
      MODE_INVERT:   chan_o = ChanMax - chan_i;
      MODE_CLEAR:    chan_o = clear_i ? '0 : chan_i;
      MODE_CAP:      chan_o = (chan_i > cfg_i.cap_level) ? '0 : chan_i;
      MODE_DIM:      chan_o = dim_res;
      MODE_CONTRAST: chan_o = con_res;
      MODE_COMBINE:  chan_o = sum_avg[ChanW:1];
      default:       chan_o = chan_i;
    endcase
  end

endmodule
`default_nettype wire

@@ design/rpe_merge.sv @@
`default_nettype none
module rpe_merge
  import rpe_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             swap_i,
  input  wire logic [ChanW-1:0] red_lane_i,
  input  wire logic [ChanW-1:0] green_lane_i,
  input  wire logic [ChanW-1:0] blue_lane_i,
  input  wire logic [ChanW-1:0] red_raw_i,
  input  wire logic [ChanW-1:0] blue_raw_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output pix_out_t              out_data_o
);

  logic     valid_q;
  pix_out_t data_q;
  pix_out_t data_d;

  // Swap mode bypasses the red and blue lanes: red and blue cross over.
  always_comb begin
    data_d.green_out = green_lane_i;
    if (swap_i) begin
      data_d.red_out  = blue_raw_i;
      data_d.blue_out = red_raw_i;
    end else begin
      data_d.red_out  = red_lane_i;
      data_d.blue_out = blue_lane_i;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

@@ design/rgb_pixel_effect_unit.sv @@
`default_nettype none
// RGB pixel effect unit: one point operation per pixel, chosen by effect_mode.
//
// Channels:
//   in   - valid/ready; one pixel plus a second pixel (used by combine only).
//   out  - valid/ready; the transformed pixel.
//   cfg  - valid/ready write port; cfg_index_i picks the register (0 mode,
//          1 clear mask, 2 cap, 3 dim, 4 contrast factor, 5 contrast low,
//          6 contrast high). Index 7 is dropped. cfg_ready_o is always high.
//          Write only while no pixel is in flight.
// Output: the result sits in the output register the cycle after
//   the input transaction.
// Throughput: 1 pixel per cycle while out_ready_i is high. Three channel lanes compute in parallel,
//   a merge stage applies the red/blue swap and holds the output register.
// Stall: when out_ready_i is low and a result is held, in_ready_o drops;
//   the held result stays stable. A new pixel is taken in the same cycle
//   the held result leaves.
// Reset: output register empties; registers go to mode invert, mask 0,
//   cap 255, dim 0, factor 0, low 0, high 255.
module rgb_pixel_effect_unit
  import rpe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire pix_in_t            in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output pix_out_t                out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [RegIdxW-1:0] cfg_index_i,
  input  wire logic [ChanW-1:0]   cfg_data_i
);

  logic [ModeW-1:0]   mode_q;
  logic [NumLane-1:0] mask_q;
  logic [ChanW-1:0]   cap_q;
  logic [ChanW-1:0]   dim_q;
  logic [ChanW-1:0]   factor_q;
  logic [ChanW-1:0]   low_q;
  logic [ChanW-1:0]   high_q;

  lane_cfg_t          lane_cfg;
  logic [ChanW-1:0]   red_res;
  logic [ChanW-1:0]   green_res;
  logic [ChanW-1:0]   blue_res;

  assign cfg_ready_o = 1'b1;

  // Register file; only the low bits of each register's width are kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_INVERT;
      mask_q   <= '0;
      cap_q    <= ChanMax;
      dim_q    <= '0;
      factor_q <= '0;
      low_q    <= '0;
      high_q   <= ChanMax;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_EFFECT_MODE:     mode_q   <= cfg_data_i[ModeW-1:0];
        REG_CLEAR_MASK:      mask_q   <= cfg_data_i[NumLane-1:0];
        REG_CAP_LEVEL:       cap_q    <= cfg_data_i;
        REG_DIM_AMOUNT:      dim_q    <= cfg_data_i;
        REG_CONTRAST_FACTOR: factor_q <= cfg_data_i;
        REG_CONTRAST_LOW:    low_q    <= cfg_data_i;
        REG_CONTRAST_HIGH:   high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign lane_cfg.mode            = mode_q;
  assign lane_cfg.cap_level       = cap_q;
  assign lane_cfg.dim_amount      = dim_q;
  assign lane_cfg.contrast_factor = factor_q;
  assign lane_cfg.contrast_low    = low_q;
  assign lane_cfg.contrast_high   = high_q;

  // One lane per color channel; clear mask bit 0 red, 1 green, 2 blue.
  rpe_lane u_lane_red (
    .cfg_i   (lane_cfg),
    .clear_i (mask_q[0]),
    .chan_i  (in_data_i.red_in),
    .other_i (in_data_i.second_red),
    .chan_o  (red_res)
  );

  rpe_lane u_lane_green (
    .cfg_i   (lane_cfg),
    .clear_i (mask_q[1]),
    .chan_i  (in_data_i.green_in),
    .other_i (in_data_i.second_green),
    .chan_o  (green_res)
  );

  rpe_lane u_lane_blue (
    .cfg_i   (lane_cfg),
    .clear_i (mask_q[2]),
    .chan_i  (in_data_i.blue_in),
    .other_i (in_data_i.second_blue),
    .chan_o  (blue_res)
  );

  rpe_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .swap_i       (mode_q == MODE_SWAP),
    .red_lane_i   (red_res),
    .green_lane_i (green_res),
    .blue_lane_i  (blue_res),
    .red_raw_i    (in_data_i.red_in),
    .blue_raw_i   (in_data_i.blue_in),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rpe_pkg::*;

  // Codes outside the package enums: the spare mode code and the spare register slot.
  localparam logic [ModeW-1:0]   MODE_PASS  = 3'd7;
  localparam logic [RegIdxW-1:0] REG_UNUSED = 3'd7;

  localparam int unsigned TargetItems  = 1350;
  localparam int unsigned QuietLimit   = 5000;  // cycles with no transaction at all
  localparam int unsigned LongHold     = 150;   // receiver back-pressure stretch
  localparam int unsigned SettleCycles = 4;     // margin after the drain for the pipe to settle

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  pix_in_t             in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  pix_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [RegIdxW-1:0]  cfg_index = '0;
  logic [ChanW-1:0]    cfg_data = '0;

  // Shadow copy of the register file, tracked from cfg transactions.
  logic [ModeW-1:0] cur_mode   = MODE_INVERT;
  logic [2:0]       cur_mask   = 3'b000;
  logic [ChanW-1:0] cur_cap    = 8'd255;
  logic [ChanW-1:0] cur_dim    = 8'd0;
  logic [ChanW-1:0] cur_factor = 8'd0;
  logic [ChanW-1:0] cur_low    = 8'd0;
  logic [ChanW-1:0] cur_high   = 8'd255;

  pix_in_t     pixel_backlog[$];     // pixels waiting for the driver
  pix_out_t    predicted_pixels[$];  // expected outputs, oldest first
  int unsigned items_sent    = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned send_gap      = 0;
  int unsigned hold_left     = 0;
  bit          steady_phase  = 1'b0;  // no random idling on either side while set

  rgb_pixel_effect_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [ChanW-1:0] effect_on_channel(logic [ChanW-1:0] v,
                                                         logic [ChanW-1:0] other,
                                                         logic [1:0] lane);
    logic [ChanW:0] sum;
    case (cur_mode)
      MODE_INVERT: return ChanMax - v;
      MODE_CLEAR:  return cur_mask[lane] ? '0 : v;
      MODE_CAP:    return (v > cur_cap) ? '0 : v;
      MODE_DIM:    return (v <= cur_dim) ? '0 : v - cur_dim;
      MODE_CONTRAST: begin
        // high threshold is checked first, so it wins when the ranges overlap
        if (v >= cur_high) begin
          sum = {1'b0, v} + {1'b0, cur_factor};
          return (sum > {1'b0, ChanMax}) ? ChanMax : sum[ChanW-1:0];
        end
        if (v <= cur_low) return (v <= cur_factor) ? '0 : v - cur_factor;
        return v;
      end
      MODE_COMBINE: begin
        sum = {1'b0, v} + {1'b0, other};
        return sum[ChanW:1];
      end
      default: return v;  // spare code: pass through
    endcase
  endfunction

  function automatic pix_out_t apply_effect(pix_in_t p);
    pix_out_t r;
    if (cur_mode == MODE_SWAP) begin
      r.red_out   = p.blue_in;
      r.green_out = p.green_in;
      r.blue_out  = p.red_in;
    end else begin
      r.red_out   = effect_on_channel(p.red_in,   p.second_red,   2'd0);
      r.green_out = effect_on_channel(p.green_in, p.second_green, 2'd1);
      r.blue_out  = effect_on_channel(p.blue_in,  p.second_blue,  2'd2);
    end
    return r;
  endfunction

  // Registers keep only their low bits; the spare index is dropped.
  function automatic void note_reg_write(logic [RegIdxW-1:0] idx, logic [ChanW-1:0] val);
    case (idx)
      REG_EFFECT_MODE:     cur_mode   = val[ModeW-1:0];
      REG_CLEAR_MASK:      cur_mask   = val[2:0];
      REG_CAP_LEVEL:       cur_cap    = val;
      REG_DIM_AMOUNT:      cur_dim    = val;
      REG_CONTRAST_FACTOR: cur_factor = val;
      REG_CONTRAST_LOW:    cur_low    = val;
      REG_CONTRAST_HIGH:   cur_high   = val;
      default: ;
    endcase
  endfunction

  task automatic check_chan(string name, logic [ChanW-1:0] want, logic [ChanW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops the backlog, holds valid and payload until the transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pixel_backlog.size() > 0) begin
        in_data  <= pixel_backlog.pop_front();
        in_valid <= 1'b1;
        send_gap = steady_phase ? 0 : idle_length();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold whenever one is requested
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_requests > holds_served) begin
      holds_served++;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (steady_phase || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      hold_left = idle_length();
      out_ready <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: output checked before the new input is predicted, so an output
  // with nothing queued is never matched against a same-edge prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    pix_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (predicted_pixels.size() == 0) begin
          $display("%0t: unexpected output transaction, expected none, got %h",
                   $time, out_data);
          mismatches++;
        end else begin
          want = predicted_pixels.pop_front();
          check_chan("red_out",   want.red_out,   out_data.red_out);
          check_chan("green_out", want.green_out, out_data.green_out);
          check_chan("blue_out",  want.blue_out,  out_data.blue_out);
        end
      end
      if (in_valid && in_ready) predicted_pixels.push_back(apply_effect(in_data));
      if (cfg_valid && cfg_ready) note_reg_write(cfg_index, cfg_data);
    end
  end

  // Watchdog on quiet cycles.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= QuietLimit) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, QuietLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One cfg transaction; called only while the block is drained.
  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [ChanW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Waits until nothing is queued, offered or expected, then lets the pipe settle.
  task automatic drain_block();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || in_valid || predicted_pixels.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic pix_in_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic [7:0] r2, logic [7:0] g2, logic [7:0] b2);
    pix_in_t p;
    p.red_in       = r;
    p.green_in     = g;
    p.blue_in      = b;
    p.second_red   = r2;
    p.second_green = g2;
    p.second_blue  = b2;
    return p;
  endfunction

  task automatic push_pixel(pix_in_t p);
    pixel_backlog.push_back(p);
    items_sent++;
  endtask

  // Channel values lean on the extremes and on the live thresholds.
  function automatic logic [ChanW-1:0] pick_chan();
    int unsigned r;
    logic [ChanW-1:0] base;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return ChanMax;
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0: base = cur_cap;
        1: base = cur_dim;
        2: base = cur_low;
        default: base = cur_high;
      endcase
      return ChanW'(base + $urandom_range(0, 2) - 1);
    end
    return ChanW'($urandom_range(0, 255));
  endfunction

  function automatic logic [ChanW-1:0] pick_reg_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return ChanMax;
    return ChanW'($urandom_range(0, 255));
  endfunction

  initial begin : stim
    int unsigned phase;
    int unsigned n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: invert mode with default thresholds.
    push_pixel(make_pixel(8'h00, 8'h7F, 8'hFF, 8'h12, 8'h34, 8'h56));
    drain_block();

    // Directed pass. Mask write carries extra high bits (keeps 3'b101); the
    // contrast thresholds overlap so the high test has to win; the spare index
    // write must not disturb anything.
    write_reg(REG_CLEAR_MASK, 8'hFD);
    write_reg(REG_CAP_LEVEL, 8'h80);
    write_reg(REG_DIM_AMOUNT, 8'h40);
    write_reg(REG_CONTRAST_FACTOR, 8'h30);
    write_reg(REG_CONTRAST_LOW, 8'hC0);
    write_reg(REG_CONTRAST_HIGH, 8'h40);
    write_reg(REG_UNUSED, 8'hFF);
    for (int m = MODE_INVERT; m <= MODE_PASS; m++) begin
      // high bits of the mode write are dropped; m = 7 is the spare code
      write_reg(REG_EFFECT_MODE, {5'b10101, m[ModeW-1:0]});
      push_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
      push_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      push_pixel(make_pixel(8'h3F, 8'h40, 8'hC1, 8'h55, 8'hAA, 8'h01));
      drain_block();
    end

    // Random phases: new settings, then a burst of pixels, then a full drain.
    phase = 0;
    while (items_sent < TargetItems) begin
      write_reg(REG_EFFECT_MODE, ChanW'($urandom_range(0, 255)));
      for (int i = REG_CLEAR_MASK; i <= REG_CONTRAST_HIGH; i++)
        if ($urandom_range(0, 1)) write_reg(i[RegIdxW-1:0], pick_reg_value());
      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, pick_reg_value());

      steady_phase = ($urandom_range(0, 3) == 0);
      // long receiver hold while the sender keeps offering: fills the block
      if (phase == 1 || phase % 7 == 3) hold_requests++;
      n = $urandom_range(20, 80);
      repeat (n)
        push_pixel(make_pixel(pick_chan(), pick_chan(), pick_chan(),
                              pick_chan(), pick_chan(), pick_chan()));
      drain_block();
      steady_phase = 1'b0;
      phase++;
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ rgb_pixel_effect_unit.f @@
design/rpe_pkg.sv
design/rpe_lane.sv
design/rpe_merge.sv
design/rgb_pixel_effect_unit.sv
bench/testbench.sv
